// ----- rtl/pfa_pkg.sv -----
// shared types and codes for the page frame allocator
// no dependencies
`timescale 1ns / 1ps

package pfa_pkg;

    localparam int FRAMES_DEF = 256;

    localparam logic [1:0] ST_FREE  = 2'd0;
    localparam logic [1:0] ST_DIRTY = 2'd1;
    localparam logic [1:0] ST_CLEAN = 2'd2;
    localparam logic [1:0] ST_FIXED = 2'd3;

    localparam logic [2:0] FN_INIT     = 3'd0;
    localparam logic [2:0] FN_ALLOC    = 3'd1;
    localparam logic [2:0] FN_FREE_RUN = 3'd2;
    localparam logic [2:0] FN_FREE_OWN = 3'd3;
    localparam logic [2:0] FN_UPDATE   = 3'd4;
    localparam logic [2:0] FN_LRU      = 3'd5;

    typedef struct packed {
        logic [1:0]  st;
        logic [7:0]  owner;
        logic        kind;
        logic [8:0]  len;
        logic        head;
        logic [31:0] stamp;
    } t_entry;

    typedef struct packed {
        logic        start;
        logic        shift;
        logic        fill;
        logic [2:0]  func;
        logic [8:0]  n;
        logic [8:0]  rsv;
        logic [7:0]  sel;
        logic [7:0]  owner;
        logic        kind;
        logic        dirty;
        logic [31:0] now;
    } t_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FILL,
        S_DONE
    } t_state;

endpackage

// ----- rtl/pfa_cell.sv -----
// one frame entry of the rotating frame ring
// depends on pfa_pkg
`timescale 1ns / 1ps

module pfa_cell import pfa_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  t_entry i_d,
    output t_entry o_q
);

    t_entry r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_en) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

// ----- rtl/pfa_step.sv -----
// per-frame operation unit at the head of the ring, with scan state and results
// depends on pfa_pkg
`timescale 1ns / 1ps

module pfa_step import pfa_pkg::*; #(
    parameter int FRAMES = FRAMES_DEF,
    localparam int IW = $clog2(FRAMES),
    localparam int FW = $clog2(FRAMES + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_ctl          i_ctl,
    input  logic [IW-1:0] i_idx,
    input  t_entry        i_e,
    output t_entry        o_e,
    output logic          o_found,
    output logic [8:0]    o_cnt,
    output logic          o_ok,
    output logic [7:0]    o_fout,
    output logic          o_vd,
    output logic [FW-1:0] o_free
);

    localparam int CW = (FW > 9) ? FW : 9;

    logic [8:0]    r_cnt, n_cnt, r_rem, n_rem;
    logic          r_found, n_found, r_ok, n_ok, r_vd, n_vd;
    logic [IW-1:0] r_start, n_start;
    logic [31:0]   r_best, n_best;
    logic [7:0]    r_fout, n_fout;
    logic [FW-1:0] r_free, n_free;

    logic [CW-1:0] w_i, w_sel, w_n, w_rsv, w_st, w_diff;
    logic          w_trig, w_rel, w_cand;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_rem   <= '0;
            r_found <= 1'b0;
            r_ok    <= 1'b0;
            r_vd    <= 1'b0;
            r_start <= '0;
            r_best  <= '0;
            r_fout  <= '0;
            r_free  <= FW'(FRAMES);
        end else begin
            r_cnt   <= n_cnt;
            r_rem   <= n_rem;
            r_found <= n_found;
            r_ok    <= n_ok;
            r_vd    <= n_vd;
            r_start <= n_start;
            r_best  <= n_best;
            r_fout  <= n_fout;
            r_free  <= n_free;
        end
    end

    always_comb begin
        w_i    = CW'(i_idx);
        w_sel  = CW'(i_ctl.sel);
        w_n    = CW'(i_ctl.n);
        w_rsv  = CW'(i_ctl.rsv);
        w_st   = CW'(r_start);
        w_diff = CW'(i_idx - r_start);
        w_trig = (i_ctl.func == FN_FREE_RUN) ? (w_i == w_sel && i_e.head)
                                             : (i_e.head && i_e.owner == i_ctl.owner);
        w_rel  = 1'b0;
        w_cand = (i_e.st == ST_DIRTY || i_e.st == ST_CLEAN) && i_e.kind
                 && i_e.owner != 8'd0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_found = r_found;
        n_ok    = r_ok;
        n_vd    = r_vd;
        n_start = r_start;
        n_best  = r_best;
        n_fout  = r_fout;
        n_free  = r_free;
        o_e     = i_e;
        if (i_ctl.start) begin
            n_cnt   = '0;
            n_rem   = '0;
            n_found = 1'b0;
            n_ok    = 1'b0;
            n_vd    = 1'b0;
            n_fout  = '0;
            n_best  = i_ctl.now;
        end else if (i_ctl.shift) begin
            unique case (i_ctl.func)
                FN_INIT: begin
                    o_e    = '0;
                    o_e.st = (w_i < w_rsv) ? ST_FIXED : ST_FREE;
                    n_ok   = 1'b1;
                    n_free = (w_rsv >= CW'(FRAMES)) ? '0 : FW'(CW'(FRAMES) - w_rsv);
                end
                FN_ALLOC: begin
                    if (i_ctl.fill) begin
                        if (r_found && w_i >= w_st && w_diff < w_n) begin
                            o_e.st    = ST_DIRTY;
                            o_e.owner = i_ctl.owner;
                            o_e.kind  = i_ctl.kind;
                            o_e.len   = i_ctl.n;
                            o_e.head  = (i_idx == r_start);
                            o_e.stamp = i_ctl.now;
                            if (i_idx == r_start) begin
                                n_ok   = 1'b1;
                                n_fout = w_st[7:0];
                                n_free = r_free - FW'(i_ctl.n);
                            end
                        end
                    end else if (!r_found) begin
                        if (i_e.st != ST_FREE) begin
                            n_cnt = '0;
                        end else begin
                            n_cnt = r_cnt + 9'd1;
                            if (r_cnt + 9'd1 == i_ctl.n) begin
                                n_found = 1'b1;
                                n_start = i_idx - IW'(i_ctl.n - 9'd1);
                            end
                        end
                    end
                end
                FN_FREE_RUN, FN_FREE_OWN: begin
                    if (r_rem == 9'd0 && w_trig) begin
                        n_ok = 1'b1;
                        if (i_e.len != 9'd0) begin
                            w_rel = 1'b1;
                            n_rem = i_e.len - 9'd1;
                        end else begin
                            o_e.head = 1'b0;
                        end
                    end else if (r_rem != 9'd0) begin
                        w_rel = 1'b1;
                        n_rem = r_rem - 9'd1;
                    end
                    if (w_rel) begin
                        if (i_e.st != ST_FREE) n_free = r_free + FW'(1);
                        o_e.st    = ST_FREE;
                        o_e.owner = '0;
                        o_e.kind  = 1'b0;
                        o_e.len   = '0;
                        o_e.head  = 1'b0;
                    end
                end
                FN_UPDATE: begin
                    if (w_i == w_sel) begin
                        if (i_e.st == ST_FREE) n_free = r_free - FW'(1);
                        o_e.st    = i_ctl.dirty ? ST_DIRTY : ST_CLEAN;
                        o_e.owner = i_ctl.owner;
                        o_e.kind  = i_ctl.kind;
                        o_e.len   = 9'd1;
                        o_e.head  = 1'b1;
                        o_e.stamp = i_ctl.now;
                        n_ok      = 1'b1;
                        n_fout    = i_ctl.sel;
                    end
                end
                FN_LRU: begin
                    if (w_cand && i_e.stamp < r_best) begin
                        n_best = i_e.stamp;
                        n_ok   = 1'b1;
                        n_fout = w_i[7:0];
                        n_vd   = (i_e.st != ST_CLEAN);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_found = r_found;
    assign o_cnt   = r_cnt;
    assign o_ok    = r_ok;
    assign o_fout  = r_fout;
    assign o_vd    = r_vd;
    assign o_free  = r_free;

endmodule

// ----- rtl/page_frame_allocator_lru_top.sv -----
// sequence: alloc runs a search pass of the frame ring and, if a run was found, a second pass that writes it;
// other operations run one pass; unused codes and zero-length or too-large allocs skip the ring
// throughput: one item at a time, a new item is accepted only in idle; the frame ring rotates one entry a cycle
// during a pass past the single operation unit; the output register lets a result wait while the next runs
// reset: synchronous active low, all frames free and zeroed, free count FRAMES, reserved 0
// depends on pfa_pkg, pfa_cell, pfa_step
`timescale 1ns / 1ps

module page_frame_allocator_lru_top import pfa_pkg::*; #(
    parameter int FRAMES = FRAMES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_func,
    input  logic [8:0]  i_run_frames,
    input  logic [7:0]  i_frame_sel,
    input  logic [7:0]  i_owner_tag,
    input  logic        i_user_kind,
    input  logic        i_mark_dirty,
    input  logic [31:0] i_now_ticks,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_ok,
    output logic [7:0]  o_frame_out,
    output logic        o_victim_dirty,
    output logic [8:0]  o_free_left
);

    localparam int IW = $clog2(FRAMES);
    localparam int FW = $clog2(FRAMES + 1);
    localparam int CW = (FW > 9) ? FW : 9;

    t_state        r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic [8:0]    r_rsv;
    t_ctl          r_op, w_op;
    logic          w_accept, w_start, w_shift, w_fill, w_last, w_load;

    // result register
    logic          r_ovalid, r_ok, r_vd;
    logic [7:0]    r_fout;
    logic [8:0]    r_free_out;

    // step unit results
    logic          w_found, w_ok, w_vd, w_hit;
    logic [8:0]    w_cnt;
    logic [7:0]    w_fout;
    logic [FW-1:0] w_free;

    // frame ring: cell 0 is the frame under the step unit
    t_entry        w_q [FRAMES];
    t_entry        w_back;

    assign w_accept = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign w_last = (r_idx == IW'(FRAMES - 1));
    // the run can complete on the last frame of the search pass
    assign w_hit = (w_q[0].st == ST_FREE) && (w_cnt + 9'd1 == r_op.n);

    // operation fields come straight from the ports in the accept cycle
    always_comb begin
        if (r_state == S_IDLE) begin
            w_op.func  = i_func;
            w_op.n     = i_run_frames;
            w_op.sel   = i_frame_sel;
            w_op.owner = i_owner_tag;
            w_op.kind  = i_user_kind;
            w_op.dirty = i_mark_dirty;
            w_op.now   = i_now_ticks;
        end else begin
            w_op.func  = r_op.func;
            w_op.n     = r_op.n;
            w_op.sel   = r_op.sel;
            w_op.owner = r_op.owner;
            w_op.kind  = r_op.kind;
            w_op.dirty = r_op.dirty;
            w_op.now   = r_op.now;
        end
        w_op.rsv   = r_rsv;
        w_op.start = w_start;
        w_op.shift = w_shift;
        w_op.fill  = w_fill;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_rsv   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (i_cfg_we) r_rsv <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) r_op <= w_op;
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        w_start = 1'b0;
        w_shift = 1'b0;
        w_fill  = 1'b0;
        w_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    w_start = 1'b1;
                    n_idx   = '0;
                    // unused codes, and allocs that the free count rules out, skip the ring
                    if (i_func > FN_LRU) begin
                        n_state = S_DONE;
                    end else if (i_func == FN_ALLOC && (i_run_frames == 9'd0
                                 || CW'(i_run_frames) > CW'(w_free))) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                w_shift = 1'b1;
                n_idx   = r_idx + IW'(1);
                if (w_last) begin
                    n_idx = '0;
                    // the search pass finds the run, a second pass writes it
                    if (r_op.func == FN_ALLOC && (w_found || w_hit)) n_state = S_FILL;
                    else n_state = S_DONE;
                end
            end
            S_FILL: begin
                w_shift = 1'b1;
                w_fill  = 1'b1;
                n_idx   = r_idx + IW'(1);
                if (w_last) begin
                    n_idx   = '0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    pfa_step #(.FRAMES(FRAMES)) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_op),
        .i_idx   (r_idx),
        .i_e     (w_q[0]),
        .o_e     (w_back),
        .o_found (w_found),
        .o_cnt   (w_cnt),
        .o_ok    (w_ok),
        .o_fout  (w_fout),
        .o_vd    (w_vd),
        .o_free  (w_free)
    );

    // each cell takes its upper neighbor; the last takes the entry the step unit hands back
    for (genvar k = 0; k < FRAMES; k++) begin : g_ring
        t_entry w_d;
        if (k == FRAMES - 1) begin : g_tail
            assign w_d = w_back;
        end else begin : g_link
            assign w_d = w_q[k + 1];
        end
        pfa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_shift),
            .i_d     (w_d),
            .o_q     (w_q[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ok       <= w_ok;
            r_fout     <= w_fout;
            r_vd       <= w_vd;
            r_free_out <= 9'(CW'(w_free));
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_ok           = r_ok;
    assign o_frame_out    = r_fout;
    assign o_victim_dirty = r_vd;
    assign o_free_left    = r_free_out;

`ifndef ASSERT_OFF
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state != S_IDLE)
        else $error("accepted item left the fsm idle");
    a_pass_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && w_last && r_op.func != FN_ALLOC) |=> r_state == S_DONE)
        else $error("scan pass did not finish");
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> r_ovalid)
        else $error("finished item not presented");
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (CW'(w_free) <= CW'(FRAMES)))
        else $error("free count above frame count");
`endif

endmodule

// ----- bench/testbench.sv -----
// self-checking bench for page_frame_allocator_lru_top: frame map predictor in a scoreboard class
// depends on pfa_pkg and the page_frame_allocator_lru_top rtl
`timescale 1ns / 1ps

module testbench;
    import pfa_pkg::*;

    localparam int NFR = 256;
    localparam int CYCLE_LIMIT = 6000000;

    // one expected result
    typedef struct {
        logic       ok;
        logic [7:0] frame;
        logic       vdirty;
        logic [8:0] free_left;
    } t_alloc_result;

    // frame map shadow and the queue of predicted results
    class frame_map_board;
        logic [1:0]  st[NFR];
        logic [7:0]  own[NFR];
        logic        knd[NFR];
        int          len[NFR];
        logic        hd[NFR];
        logic [31:0] stp[NFR];
        int          free_cnt;
        int          reserved;
        int          errors;
        t_alloc_result pending[$];

        function void clear_all();
            for (int i = 0; i < NFR; i++) begin
                st[i] = ST_FREE; own[i] = 0; knd[i] = 0;
                len[i] = 0; hd[i] = 0; stp[i] = 0;
            end
            free_cnt = NFR;
            reserved = 0;
            errors = 0;
        endfunction

        function int release_run(int h);
            int c;
            c = 0;
            if (h >= NFR || !hd[h]) return 0;
            for (int j = 0; j < len[h] && h + j < NFR; j++) begin
                if (st[h+j] != ST_FREE) c++;
                st[h+j] = ST_FREE; own[h+j] = 0; knd[h+j] = 0; hd[h+j] = 0;
                if (j != 0) len[h+j] = 0;
            end
            len[h] = 0;
            free_cnt += c;
            return 1;
        endfunction

        // predict the result of one accepted item
        function void note_item(logic [2:0] fn, logic [8:0] n, logic [7:0] sel,
                                logic [7:0] ow, logic kd, logic dt, logic [31:0] now);
            t_alloc_result r;
            int cnt, r0, st0;
            logic [31:0] best;
            r = '{ok: 0, frame: 0, vdirty: 0, free_left: 0};
            case (fn)
                FN_INIT: begin
                    r0 = reserved < NFR ? reserved : NFR;
                    for (int i = 0; i < NFR; i++) begin
                        st[i] = i < r0 ? ST_FIXED : ST_FREE;
                        own[i] = 0; knd[i] = 0; len[i] = 0; hd[i] = 0; stp[i] = 0;
                    end
                    free_cnt = NFR - r0;
                    r.ok = 1;
                end
                FN_ALLOC: begin
                    if (n != 0 && n <= free_cnt) begin
                        cnt = 0;
                        for (int i = 0; i < NFR; i++) begin
                            if (st[i] != ST_FREE) begin
                                cnt = 0;
                            end else begin
                                cnt++;
                                if (cnt == n) begin
                                    st0 = i + 1 - n;
                                    for (int f = st0; f <= i; f++) begin
                                        st[f] = ST_DIRTY; own[f] = ow; knd[f] = kd;
                                        len[f] = n; hd[f] = (f == st0); stp[f] = now;
                                    end
                                    free_cnt -= n;
                                    r.ok = 1;
                                    r.frame = st0[7:0];
                                    break;
                                end
                            end
                        end
                    end
                end
                FN_FREE_RUN: r.ok = release_run(sel);
                FN_FREE_OWN: begin
                    for (int i = 0; i < NFR; i++)
                        if (hd[i] && own[i] == ow && release_run(i)) r.ok = 1;
                end
                FN_UPDATE: begin
                    if (st[sel] == ST_FREE) free_cnt--;
                    st[sel] = dt ? ST_DIRTY : ST_CLEAN;
                    own[sel] = ow; knd[sel] = kd; len[sel] = 1; hd[sel] = 1;
                    stp[sel] = now;
                    r.ok = 1;
                    r.frame = sel;
                end
                FN_LRU: begin
                    best = now;
                    for (int i = 0; i < NFR; i++) begin
                        if ((st[i] == ST_DIRTY || st[i] == ST_CLEAN) && knd[i] && own[i] != 0
                            && stp[i] < best) begin
                            best = stp[i];
                            r.ok = 1;
                            r.frame = i[7:0];
                            r.vdirty = (st[i] != ST_CLEAN);
                        end
                    end
                end
                default: ;
            endcase
            r.free_left = free_cnt[8:0];
            pending.push_back(r);
        endfunction

        function void report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %0h want %0h", what, got, want);
            errors++;
        endfunction

        function void check_result(logic ok, logic [7:0] fr, logic vd, logic [8:0] fl);
            t_alloc_result e;
            if (pending.size() == 0) begin
                report("unexpected result", 1, 0);
                return;
            end
            e = pending.pop_front();
            if (ok !== e.ok) report("ok", ok, e.ok);
            if (fr !== e.frame) report("frame_out", fr, e.frame);
            if (vd !== e.vdirty) report("victim_dirty", vd, e.vdirty);
            if (fl !== e.free_left) report("free_left", fl, e.free_left);
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [8:0]  cfg_wdata = 0;
    logic        in_valid = 0;
    logic        in_ready;
    logic [2:0]  func = 0;
    logic [8:0]  run_frames = 0;
    logic [7:0]  frame_sel = 0;
    logic [7:0]  owner_tag = 0;
    logic        user_kind = 0;
    logic        mark_dirty = 0;
    logic [31:0] now_ticks = 0;
    logic        out_valid;
    logic        out_ready = 0;
    logic        ok;
    logic [7:0]  frame_out;
    logic        victim_dirty;
    logic [8:0]  free_left;

    frame_map_board board;
    int  cycles = 0;
    bit  calm = 0;          // no idling in the last part
    bit  hold_rx = 0;       // long receiver hold-off requested
    logic [31:0] clock_ticks = 1000;

    page_frame_allocator_lru_top i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_func(func), .i_run_frames(run_frames), .i_frame_sel(frame_sel),
        .i_owner_tag(owner_tag), .i_user_kind(user_kind), .i_mark_dirty(mark_dirty),
        .i_now_ticks(now_ticks),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_ok(ok), .o_frame_out(frame_out), .o_victim_dirty(victim_dirty),
        .o_free_left(free_left)
    );

    always begin
        #4 clk = 1;
        #4 clk = 0;
    end

    // watchdog on total cycles
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // result side: check on the rising edge, change ready on the falling edge
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            board.check_result(ok, frame_out, victim_dirty, free_left);
    end

    initial begin : receiver
        int gap;
        @(negedge clk);
        forever begin
            if (hold_rx) begin
                out_ready <= 0;
                repeat (3000) @(negedge clk);
                hold_rx = 0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                gap = $urandom_range(1, 14);
                out_ready <= 0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1;
            @(negedge clk);
        end
    end

    // offer one item and wait for its acceptance
    task automatic send_item(logic [2:0] fn, logic [8:0] n, logic [7:0] sel,
                             logic [7:0] ow, logic kd, logic dt, logic [31:0] now);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 14);
            repeat (gap) @(negedge clk);
        end
        func <= fn; run_frames <= n; frame_sel <= sel; owner_tag <= ow;
        user_kind <= kd; mark_dirty <= dt; now_ticks <= now;
        in_valid <= 1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_item(fn, n, sel, ow, kd, dt, now);
        @(negedge clk);
        in_valid <= 0;
        // the block is busy for at least this cycle
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (board.pending.size() != 0) @(negedge clk);
        repeat (600) @(negedge clk);
    endtask

    task automatic write_reserved(int v);
        wait_drained();
        cfg_wdata <= v[8:0];
        cfg_we <= 1;
        board.reserved = v;
        @(negedge clk);
        cfg_we <= 0;
    endtask

    // mostly small runs, owners from a few tags, clock moving forward
    task automatic random_item();
        int p;
        logic [8:0] n;
        logic [31:0] now;
        p = $urandom_range(0, 99);
        clock_ticks = clock_ticks + $urandom_range(0, 40);
        now = ($urandom_range(0, 19) == 0) ? $urandom() : clock_ticks;
        n = ($urandom_range(0, 15) == 0) ? 9'($urandom_range(0, 511)) : 9'($urandom_range(1, 12));
        if (p < 2)       send_item(FN_INIT, 9'($urandom), 8'($urandom), 8'($urandom),
                                   1'($urandom), 1'($urandom), now);
        else if (p < 30) send_item(FN_ALLOC, n, 8'($urandom), 8'($urandom_range(0, 5)),
                                   1'($urandom), 1'($urandom), now);
        else if (p < 48) send_item(FN_FREE_RUN, 9'($urandom), 8'($urandom), 8'($urandom),
                                   1'($urandom), 1'($urandom), now);
        else if (p < 56) send_item(FN_FREE_OWN, 9'($urandom), 8'($urandom),
                                   8'($urandom_range(0, 5)), 1'($urandom), 1'($urandom), now);
        else if (p < 76) send_item(FN_UPDATE, 9'($urandom), 8'($urandom),
                                   8'($urandom_range(0, 5)), 1'($urandom), 1'($urandom), now);
        else if (p < 96) send_item(FN_LRU, 9'($urandom), 8'($urandom), 8'($urandom),
                                   1'($urandom), 1'($urandom), now);
        else             send_item(3'($urandom_range(6, 7)), 9'($urandom), 8'($urandom),
                                   8'($urandom), 1'($urandom), 1'($urandom), $urandom);
    endtask

    initial begin
        board = new();
        board.clear_all();
        repeat (12) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // directed: extremes and special cases
        send_item(FN_ALLOC, 0, 0, 1, 1, 0, 5);              // zero frames
        send_item(FN_ALLOC, 9'd256, 0, 8'hff, 1, 1, 32'hffffffff);
        send_item(FN_FREE_RUN, 0, 8'd0, 0, 0, 0, 0);        // head of whole map
        send_item(FN_ALLOC, 9'd257, 0, 1, 1, 0, 1);         // more than free
        send_item(FN_ALLOC, 9'd4, 0, 0, 1, 0, 10);          // ownerless run
        send_item(FN_ALLOC, 9'd3, 0, 2, 1, 0, 0);
        send_item(FN_FREE_RUN, 0, 8'd1, 0, 0, 0, 0);        // non-head
        send_item(FN_UPDATE, 0, 8'd255, 8'hff, 1, 1, 32'hffffffff);
        send_item(FN_UPDATE, 0, 8'd200, 3, 1, 0, 7);        // free frame updated clean
        send_item(FN_UPDATE, 0, 8'd2, 3, 1, 1, 3);          // inside a run
        send_item(FN_LRU, 0, 0, 0, 0, 0, 32'hffffffff);
        send_item(FN_LRU, 0, 0, 0, 0, 0, 0);                // nothing below zero
        send_item(FN_FREE_OWN, 0, 0, 8'd0, 0, 0, 0);        // owner 0 frees ownerless
        send_item(FN_FREE_OWN, 0, 0, 8'd9, 0, 0, 0);        // no such owner
        send_item(FN_FREE_OWN, 0, 0, 8'd3, 0, 0, 0);
        send_item(3'd6, 9'h1ff, 8'hff, 8'hff, 1, 1, 32'hffffffff);
        send_item(3'd7, 0, 0, 0, 0, 0, 0);
        write_reserved(256);
        send_item(FN_INIT, 0, 0, 0, 0, 0, 0);
        send_item(FN_ALLOC, 1, 0, 1, 1, 1, 1);              // map full of fixed frames
        write_reserved(511);
        send_item(FN_INIT, 0, 0, 0, 0, 0, 0);
        write_reserved(0);
        send_item(FN_INIT, 0, 0, 0, 0, 0, 0);

        // random phases, each with its own reserved count
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                1: write_reserved(1);
                2: write_reserved(255);
                3: write_reserved($urandom_range(2, 200));
                4: write_reserved($urandom_range(0, 511));
                5: write_reserved(16);
                default: ;
            endcase
            send_item(FN_INIT, 0, 0, 0, 0, 0, 0);
            if (ph == 2) hold_rx = 1;    // receiver stalls while items keep coming
            if (ph == 5) calm = 1;
            for (int k = 0; k < 300; k++) begin
                random_item();
                if (ph == 3 && k == 150) wait_drained();   // sender pause
            end
        end

        wait_drained();
        if (board.errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule
